[hw/rtl/ifmt_pkg.sv]
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types, constants and helpers of the integer field formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  localparam int MAX_FIELD_CHARS = 11;
  localparam int IDX_W           = $clog2(MAX_FIELD_CHARS);
  localparam int CNT_W           = $clog2(MAX_FIELD_CHARS + 3);

  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;

  typedef enum logic [2:0] {
    CMD_D  = 3'd0,
    CMD_U  = 3'd1,
    CMD_O  = 3'd2,
    CMD_X  = 3'd3,
    CMD_XU = 3'd4,
    CMD_P  = 3'd5
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BASE_10,
    BASE_8,
    BASE_16
  } base_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [31:0]       value;
    logic              alt_form;
    logic              zero_pad;
    logic              plus_sign;
    logic              space_sign;
    logic signed [7:0] field_width;
    logic signed [7:0] precision;
    logic [15:0]       room;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic size;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic conv_done;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end else if (lower) begin
      return CH_LOWER + d8 - 8'd10;
    end else begin
      return CH_UPPER + d8 - 8'd10;
    end
  endfunction

endpackage

[hw/rtl/ifmt_ctrl.sv]
// ----------------------------------------------------------------------------
// ifmt_ctrl
// Sequencer: accept, digit conversion, field sizing, character output.
// ----------------------------------------------------------------------------
module ifmt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ifmt_pkg::dp_status_t status,
  output ifmt_pkg::dp_cmd_t    cmd
);
  import ifmt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.item_ok) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (status.conv_done) begin
          state_next = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
      end
      ST_SIZE: begin
        cmd.size = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[hw/rtl/ifmt_datapath.sv]
// ----------------------------------------------------------------------------
// ifmt_datapath
// Request decode, digit extraction by base, digit store and output register.
// ----------------------------------------------------------------------------
module ifmt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  ifmt_pkg::in_item_t   in_data,
  input  ifmt_pkg::dp_cmd_t    cmd,
  input  logic                 out_stall,
  output ifmt_pkg::dp_status_t status,
  output logic                 out_valid,
  output ifmt_pkg::out_item_t  out_data
);
  import ifmt_pkg::*;

  function automatic logic [CNT_W-1:0] clamp_len(input logic signed [8:0] v);
    if (v <= 9'sd0) begin
      return '0;
    end else if (v > $signed(9'(MAX_FIELD_CHARS))) begin
      return CNT_W'(MAX_FIELD_CHARS);
    end else begin
      return v[CNT_W-1:0];
    end
  endfunction

  // decode of the incoming request
  logic              is_d;
  logic              is_hex;
  logic              use_pfx;
  logic              neg;
  logic signed [8:0] fw9;
  logic signed [8:0] pr9;
  logic signed [8:0] pr_z;
  logic [31:0]       mag_load;
  logic [1:0]        plen_load;
  logic [7:0]        pfx0_load;
  base_sel_t         base_load;

  // per-request registers
  logic [31:0]      mag;
  base_sel_t        base_sel;
  logic             lower;
  logic [1:0]       plen;
  logic [7:0]       pfx0;
  logic [CNT_W-1:0] pr_c;
  logic [CNT_W-1:0] fw_c;
  logic [15:0]      room_q;
  logic [CNT_W-1:0] ndig;
  logic [3:0]       digits [MAX_FIELD_CHARS];
  logic [CNT_W-1:0] flen;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] pos;

  // conversion step
  logic [63:0]      prod;
  logic [31:0]      q10;
  logic [3:0]       t10;
  logic [31:0]      quot;
  logic [3:0]       rem;

  // sizing and output selection
  logic [CNT_W-1:0] flen_calc;
  logic [CNT_W-1:0] sum_calc;
  logic [CNT_W-1:0] fi;
  logic [7:0]       char_sel;

  always_comb begin
    is_d    = (in_data.cmd == CMD_D);
    is_hex  = (in_data.cmd == CMD_X) || (in_data.cmd == CMD_XU) || (in_data.cmd == CMD_P);
    use_pfx = is_hex && (in_data.alt_form || (in_data.cmd == CMD_P));
    neg     = is_d && in_data.value[31];
    mag_load = neg ? (~in_data.value + 32'd1) : in_data.value;
    fw9  = {in_data.field_width[7], in_data.field_width} - {7'd0, use_pfx, 1'b0};
    pr9  = {in_data.precision[7], in_data.precision};
    pr_z = (in_data.zero_pad && (pr9 < fw9)) ? fw9 : pr9;
    if (is_d) begin
      plen_load = (neg || in_data.plus_sign || in_data.space_sign) ? 2'd1 : 2'd0;
    end else begin
      plen_load = use_pfx ? 2'd2 : 2'd0;
    end
    priority if (neg) begin
      pfx0_load = CH_MINUS;
    end else if (is_d && in_data.plus_sign) begin
      pfx0_load = CH_PLUS;
    end else if (is_d && in_data.space_sign) begin
      pfx0_load = CH_SPACE;
    end else begin
      pfx0_load = CH_ZERO;
    end
    if (in_data.cmd == CMD_O) begin
      base_load = BASE_8;
    end else if (is_hex) begin
      base_load = BASE_16;
    end else begin
      base_load = BASE_10;
    end
  end

  always_comb begin
    prod = mag * RECIP10;
    q10  = {3'b000, prod[63:35]};
    t10  = {q10[0], 3'b000} + {q10[2:0], 1'b0};
    unique case (base_sel)
      BASE_8: begin
        quot = {3'b000, mag[31:3]};
        rem  = {1'b0, mag[2:0]};
      end
      BASE_16: begin
        quot = {4'b0000, mag[31:4]};
        rem  = mag[3:0];
      end
      default: begin
        quot = q10;
        rem  = mag[3:0] - t10;
      end
    endcase
  end

  always_comb begin
    flen_calc = ndig;
    if (pr_c > flen_calc) begin
      flen_calc = pr_c;
    end
    if (fw_c > flen_calc) begin
      flen_calc = fw_c;
    end
    sum_calc = flen_calc + {{(CNT_W-2){1'b0}}, plen};
  end

  always_comb begin
    fi = flen - 1'b1 - (pos - {{(CNT_W-2){1'b0}}, plen});
    priority if (pos < {{(CNT_W-2){1'b0}}, plen}) begin
      char_sel = (pos == '0) ? pfx0 : CH_X;
    end else if (fi < ndig) begin
      char_sel = digit_char(digits[fi[IDX_W-1:0]], lower);
    end else if (fi < pr_c) begin
      char_sel = CH_ZERO;
    end else begin
      char_sel = CH_SPACE;
    end
  end

  always_comb begin
    status.item_ok   = (in_data.room != 16'd0) && (in_data.cmd <= CMD_P);
    status.conv_done = (quot == 32'd0) || (ndig == CNT_W'(MAX_FIELD_CHARS - 1));
    status.emit_last = (pos == total - 1'b1);
    status.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= mag_load;
      base_sel <= base_load;
      lower    <= (in_data.cmd == CMD_X) || (in_data.cmd == CMD_P);
      plen     <= plen_load;
      pfx0     <= pfx0_load;
      pr_c     <= is_d ? '0 : clamp_len(pr_z);
      fw_c     <= is_d ? '0 : clamp_len(fw9);
      room_q   <= in_data.room;
      ndig     <= '0;
    end
    if (cmd.conv_step) begin
      digits[ndig[IDX_W-1:0]] <= rem;
      mag  <= quot;
      ndig <= ndig + 1'b1;
    end
    if (cmd.size) begin
      flen  <= flen_calc;
      total <= (room_q < 16'(sum_calc)) ? room_q[CNT_W-1:0] : sum_calc;
      pos   <= '0;
    end
    if (cmd.emit) begin
      pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.out_char <= char_sel;
      out_data.last     <= status.emit_last;
    end
  end

endmodule

[hw/rtl/integer_field_formatter_top.sv]
// ----------------------------------------------------------------------------
// integer_field_formatter_top
// Formats one integer conversion request (d, u, o, x, X, p) as ASCII beats.
//
// Input channel in_valid/in_stall/in_data takes one request per beat. Output
// channel out_valid/out_stall/out_data gives one character per beat, most
// significant first, with last set on the final character of the request.
// A request with zero room or an undefined kind gives no beats.
// After acceptance the digit unit produces one digit per cycle (1 to 11
// digits, set by the value and base), the size state sizes the field, and
// then one character leaves per cycle while the output is not stalled,
// through the output register (up to 13 characters). A request occupies
// the sequencer through conversion, sizing and output before the next one
// is taken. The next request is accepted while the last beat still waits.
// A stalled output holds its beat and pauses the sequencer.
// Reset returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module integer_field_formatter_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ifmt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ifmt_pkg::out_item_t out_data
);
  import ifmt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ifmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ifmt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && status.item_ok) |=> in_stall)
    else $error("formatter took a request without going busy");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("character pushed over a held beat");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.emit_last) |=> !in_stall)
    else $error("sequencer not idle after final character");

  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (out_valid && (out_data.last == $past(status.emit_last))))
    else $error("last flag does not match final character");

endmodule
